@@ src/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// Shared widths, request and status codes, and the controller command
// struct for the bounded LIFO stack.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned MODE_W      = 3;
  localparam int unsigned OFFSET_W    = 6;
  localparam int unsigned CAP_W       = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_TOP    = 3'd2,
    MODE_BOTTOM = 3'd3,
    MODE_PEEK   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_BAD_PEEK  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
  } ctrl_cmd_t;

endpackage

@@ src/bls_ram.sv @@
// ----------------------------------------------------------------------------
// bls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bls_ctrl.sv @@
// ----------------------------------------------------------------------------
// bls_ctrl
// Request sequencer: takes one item in idle, then holds the result until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module bls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bls_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_RESP);
  assign cmd_o.load    = in_valid_i && (state_q == S_IDLE);

endmodule

@@ src/bls_datapath.sv @@
// ----------------------------------------------------------------------------
// bls_datapath
// Stack pointer, capacity register, storage RAM and result registers.
// ----------------------------------------------------------------------------
module bls_datapath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bls_pkg::ctrl_cmd_t                cmd_i,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic [bls_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [DATA_WIDTH-1:0]      push_value_i,
  input  logic [bls_pkg::OFFSET_W-1:0]      peek_offset_i,
  output logic signed [DATA_WIDTH-1:0]      read_data_o,
  output logic [bls_pkg::STATUS_W-1:0]      status_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = (CW > bls_pkg::CAP_W) ? CW : bls_pkg::CAP_W;

  logic [bls_pkg::CAP_W-1:0]    cap_q;
  logic [CW-1:0]                count_q, count_d;
  logic [bls_pkg::STATUS_W-1:0] status_q, status_d;
  logic                         empty_q, full_q;
  logic                         rd_ok_q, rd_ok_d;

  logic [EW-1:0] cap_ext, eff_cap, count_ext, off_ext, top_pos, peek_pos, next_ext;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign cap_ext   = EW'(cap_q);
  assign eff_cap   = (cap_ext > EW'(DEPTH)) ? EW'(DEPTH) : cap_ext;
  assign count_ext = EW'(count_q);
  assign off_ext   = EW'(peek_offset_i);
  assign top_pos   = count_ext - EW'(1);
  assign peek_pos  = top_pos - off_ext;

  always_comb begin
    count_d   = count_q;
    status_d  = bls_pkg::STATUS_OK;
    rd_ok_d   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = top_pos[AW-1:0];
    unique case (mode_i)
      bls_pkg::MODE_PUSH: begin
        if (count_ext >= eff_cap) begin
          status_d = bls_pkg::STATUS_OVERFLOW;
        end else begin
          ram_we  = cmd_i.load;
          count_d = count_q + CW'(1);
        end
      end
      bls_pkg::MODE_POP: begin
        if (count_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
        end else begin
          ram_re  = cmd_i.load;
          rd_ok_d = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      bls_pkg::MODE_TOP: begin
        if (count_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
        end else begin
          ram_re  = cmd_i.load;
          rd_ok_d = 1'b1;
        end
      end
      bls_pkg::MODE_BOTTOM: begin
        ram_raddr = '0;
        if (count_q == '0) begin
          status_d = bls_pkg::STATUS_UNDERFLOW;
        end else begin
          ram_re  = cmd_i.load;
          rd_ok_d = 1'b1;
        end
      end
      bls_pkg::MODE_PEEK: begin
        ram_raddr = peek_pos[AW-1:0];
        if (off_ext >= count_ext) begin
          status_d = bls_pkg::STATUS_BAD_PEEK;
        end else begin
          ram_re  = cmd_i.load;
          rd_ok_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign next_ext = EW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= bls_pkg::CAP_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        count_q <= count_d;
      end
    end
  end

  // Result fields are captured with the request and held while the output
  // side stalls.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
      empty_q  <= (count_d == '0);
      full_q   <= (next_ext >= eff_cap);
    end
  end

  bls_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign read_data_o   = rd_ok_q ? ram_rdata : '0;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign empty_flag_o  = empty_q;
  assign full_flag_o   = full_q;

endmodule

@@ src/bounded_lifo_stack.sv @@
// A request accepted at one clock edge has its result valid from the
// next cycle on, with read data coming straight from the RAM's read register.
// The controller takes no new item until the held result has been taken.
// Reset: the entry count clears to zero and capacity returns to 64; stored
// words are undefined until pushed.
// ----------------------------------------------------------------------------
// bounded_lifo_stack
// Bounded LIFO stack with push, pop, read top, read bottom and peek requests.
// ----------------------------------------------------------------------------
module bounded_lifo_stack #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bls_pkg::CAP_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bls_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [DATA_WIDTH-1:0]      push_value_i,
  input  logic [bls_pkg::OFFSET_W-1:0]      peek_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [DATA_WIDTH-1:0]      read_data_o,
  output logic [bls_pkg::STATUS_W-1:0]      status_o,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count_o,
  output logic                              empty_flag_o,
  output logic                              full_flag_o
);

  bls_pkg::ctrl_cmd_t cmd;

  bls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bls_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode_i),
    .push_value_i  (push_value_i),
    .peek_offset_i (peek_offset_i),
    .read_data_o   (read_data_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .empty_flag_o  (empty_flag_o),
    .full_flag_o   (full_flag_o)
  );

endmodule
